FILE: design/r2fft_pkg.sv
// Shared types, constants and twiddle generation for the radix-2 FFT engine.
package r2fft_pkg;

	localparam int FFT_SIZE_DEF      = 2048;
	localparam int TWIDDLE_WIDTH_DEF = 16;
	localparam int DATA_W            = 36;
	localparam int SAMPLE_W          = 24;
	localparam int INDEX_W           = 11;
	localparam int OP_W              = 2;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [INDEX_W-1:0]         index;
		logic signed [SAMPLE_W-1:0] sample_real;
		logic signed [SAMPLE_W-1:0] sample_imag;
	} fft_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] bin_real;
		logic signed [DATA_W-1:0] bin_imag;
		logic                     is_done_ack;
	} fft_out_t;

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[123:60];
	endfunction

	// Taylor series sine or cosine of pi*k/2^(lg-1), rounded to a twiddle of tw bits.
	function automatic logic [31:0] twiddle_calc(input int k, input int lg, input int tw,
			input bit want_sin);
		logic [63:0] step;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] st;
		logic [63:0] ss;
		logic [63:0] ct;
		logic [63:0] cs;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] top;
		int sh;
		step = (lg > 0) ? (PI_Q60 >> (lg - 1)) : PI_Q60;
		x = step * 64'(k);
		x2 = mul_q60(x, x);
		st = x;
		ss = x;
		ct = ONE_Q60;
		cs = ONE_Q60;
		for (int n = 1; n <= 12; n++) begin
			st = mul_q60(st, x2) / 64'((2 * n) * (2 * n + 1));
			ct = mul_q60(ct, x2) / 64'((2 * n - 1) * (2 * n));
			if ((n % 2) == 1) begin
				ss = ss - st;
				cs = cs - ct;
			end else begin
				ss = ss + st;
				cs = cs + ct;
			end
		end
		v = want_sin ? ss : cs;
		sh = 61 - tw;
		top = (64'd1 << (tw - 1)) - 64'd1;
		if (v > (64'd1 << 62)) begin
			r = 64'd0;
		end else begin
			r = (v + (64'd1 << (sh - 1))) >> sh;
			if (r > top) begin
				r = top;
			end
		end
		return r[31:0];
	endfunction

endpackage

FILE: design/radix2_fft_inverse_scaled.sv
// Top level of the in-place radix-2 FFT engine with its sequencer and butterfly pipeline.
//
// An item is a command on item, taken when start is high and busy is low.
// A load writes one sample into the frame in the accepting cycle and gives no result.
// A read gives one result, the stored bin, on the cycle after it is taken.
// A run performs the whole transform and then gives one result with is_done_ack set.
// The run first scans all N indexes for the bit-reversal swaps, one index a cycle,
// stalling wherever a swap directly follows another (at fewer than N/2 indexes),
// then does N/2 butterflies per stage over log2(N) stages. Butterflies are not issued
// back to back, because both outputs go through the single write port of the frame
// memories; after each pass the four-stage pipeline drains. Busy stays high for the
// whole run. A load leaves busy low; a read raises busy while its result is shown.
// Results are shown for one cycle with result_valid; the receiver cannot stall.
// Reset returns the sequencer to idle and clears inverse_mode; the frame memories are
// not cleared and hold undefined data until loaded. inverse_mode sits at APB address
// 0 and must be written by the user only while the block is idle; the block itself
// does not enforce this.
module radix2_fft_inverse_scaled import r2fft_pkg::*; #(
	parameter int FFT_SIZE      = FFT_SIZE_DEF,
	parameter int TWIDDLE_WIDTH = TWIDDLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  fft_in_t     item,
	output logic        result_valid,
	output fft_out_t    result
);

	localparam int AW   = $clog2(FFT_SIZE);
	localparam int TW   = TWIDDLE_WIDTH;
	localparam int QTR  = FFT_SIZE / 4;
	localparam int SGW  = $clog2(AW + 1);
	localparam int PW   = DATA_W + TW;
	localparam int SW3  = DATA_W + TW + 2;
	localparam logic [AW-1:0] HALF_LAST = AW'(FFT_SIZE / 2 - 1);
	localparam logic [SGW-1:0] STAGE_LAST = SGW'(AW - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_SWAP  = 3'd2;
	localparam logic [2:0] ST_BFLY  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_ACK   = 3'd5;

	function automatic logic [(QTR+1)*TW-1:0] build_tbl(input bit want_sin);
		logic [(QTR+1)*TW-1:0] t;
		logic [31:0] w;
		t = '0;
		for (int k = 0; k <= QTR; k++) begin
			w = twiddle_calc(k, AW, TW, want_sin);
			t[k*TW +: TW] = w[TW-1:0];
		end
		return t;
	endfunction

	localparam logic [(QTR+1)*TW-1:0] COS_TBL = build_tbl(1'b0);
	localparam logic [(QTR+1)*TW-1:0] SIN_TBL = build_tbl(1'b1);

	function automatic logic [DATA_W-1:0] sat36(input logic signed [SW3-1:0] v);
		logic signed [SW3-1:0] hi;
		logic signed [SW3-1:0] lo;
		hi = $signed({{(SW3-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end
		return v[DATA_W-1:0];
	endfunction

	logic              inv_q;
	logic [2:0]        state_q;
	logic [AW-1:0]     cnt_q;
	logic [SGW-1:0]    stage_q;
	logic              last_q;
	logic              rd_ok_q;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              swap_s1, swap_s2;
	logic [AW-1:0]     p_s1, q_s1, p_s2, q_s2, p_s3, q_s3;
	logic signed [TW-1:0] wc_s1, ws_s1;
	logic signed [PW-1:0] m_rc_s2, m_is_s2, m_rs_s2, m_ic_s2;
	logic signed [DATA_W-1:0] er_s2, ei_s2, qr_s2, qi_s2;
	logic [DATA_W-1:0] wr0_s3, wi0_s3, wr1_s3, wi1_s3;

	logic [AW-1:0]     rev;
	logic [AW-1:0]     mask;
	logic [AW-1:0]     p_iss, q_iss, k_iss;
	logic              need_swap;
	logic              issue;
	logic              advance;
	logic              accept;
	logic              in_range;
	logic [31:0]       idx32;
	logic [AW-1:0]     idx_addr;
	logic              k_hi;
	logic [AW-1:0]     kk;
	logic [TW-1:0]     cos_t, sin_t;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata_re, wdata_im;
	logic [AW-1:0]     raddr_a, raddr_b;
	logic [DATA_W-1:0] rd_re_a, rd_im_a, rd_re_b, rd_im_b;

	logic signed [SW3-1:0] tr, ti, s0, s1, d0, d1, rnd;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, inv_q} : 32'b0;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign idx32 = 32'(item.index);
	assign in_range = (idx32 < 32'(FFT_SIZE));
	assign idx_addr = idx32[AW-1:0];

	always_comb begin
		for (int b = 0; b < AW; b++) begin
			rev[b] = cnt_q[AW-1-b];
		end
		mask = (AW'(1) << stage_q) - AW'(1);
		need_swap = (rev > cnt_q);
		if (state_q == ST_SWAP) begin
			p_iss = cnt_q;
			q_iss = rev;
			k_iss = '0;
		end else begin
			p_iss = ((cnt_q >> stage_q) << (stage_q + 1'b1)) | (cnt_q & mask);
			q_iss = p_iss | (AW'(1) << stage_q);
			k_iss = (cnt_q & mask) << (SGW'(AW - 1) - stage_q);
		end
		issue = ((state_q == ST_SWAP) && need_swap && !v_s1) ||
			((state_q == ST_BFLY) && !v_s1);
		advance = ((state_q == ST_SWAP) && (!need_swap || !v_s1)) ||
			((state_q == ST_BFLY) && !v_s1);
		k_hi = (32'(k_iss) > 32'(QTR));
		kk = k_hi ? (k_iss - AW'(QTR)) : k_iss;
		cos_t = COS_TBL[int'(kk)*TW +: TW];
		sin_t = SIN_TBL[int'(kk)*TW +: TW];
	end

	assign raddr_a = (state_q == ST_IDLE) ? idx_addr : p_iss;
	assign raddr_b = q_iss;

	always_comb begin
		we = v_s3 || v_s4 || (accept && (item.op == OP_LOAD) && in_range);
		if (v_s3) begin
			waddr = p_s3;
			wdata_re = wr0_s3;
			wdata_im = wi0_s3;
		end else if (v_s4) begin
			waddr = q_s3;
			wdata_re = wr1_s3;
			wdata_im = wi1_s3;
		end else begin
			waddr = idx_addr;
			wdata_re = DATA_W'(item.sample_real);
			wdata_im = DATA_W'(item.sample_imag);
		end
	end

	r2fft_ram #(.WIDTH(DATA_W), .DEPTH(FFT_SIZE)) u_ram_re (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata_re),
		.raddr_a(raddr_a), .rdata_a(rd_re_a), .raddr_b(raddr_b), .rdata_b(rd_re_b)
	);

	r2fft_ram #(.WIDTH(DATA_W), .DEPTH(FFT_SIZE)) u_ram_im (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata_im),
		.raddr_a(raddr_a), .rdata_a(rd_im_a), .raddr_b(raddr_b), .rdata_b(rd_im_b)
	);

	always_comb begin
		rnd = $signed(SW3'(1) << (TW - 2));
		tr = (SW3'(m_rc_s2) - SW3'(m_is_s2) + rnd) >>> (TW - 1);
		ti = (SW3'(m_rs_s2) + SW3'(m_ic_s2) + rnd) >>> (TW - 1);
		s0 = SW3'(er_s2) + tr;
		s1 = SW3'(ei_s2) + ti;
		d0 = SW3'(er_s2) - tr;
		d1 = SW3'(ei_s2) - ti;
		if (inv_q) begin
			s0 = s0 >>> 1;
			s1 = s1 >>> 1;
			d0 = d0 >>> 1;
			d1 = d1 >>> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			p_s1 <= p_iss;
			q_s1 <= q_iss;
			swap_s1 <= (state_q == ST_SWAP);
			wc_s1 <= k_hi ? -$signed(sin_t) : $signed(cos_t);
			if (inv_q) begin
				ws_s1 <= k_hi ? -$signed(cos_t) : -$signed(sin_t);
			end else begin
				ws_s1 <= k_hi ? $signed(cos_t) : $signed(sin_t);
			end
		end
		if (v_s1) begin
			p_s2 <= p_s1;
			q_s2 <= q_s1;
			swap_s2 <= swap_s1;
			m_rc_s2 <= $signed(rd_re_b) * wc_s1;
			m_is_s2 <= $signed(rd_im_b) * ws_s1;
			m_rs_s2 <= $signed(rd_re_b) * ws_s1;
			m_ic_s2 <= $signed(rd_im_b) * wc_s1;
			er_s2 <= $signed(rd_re_a);
			ei_s2 <= $signed(rd_im_a);
			qr_s2 <= $signed(rd_re_b);
			qi_s2 <= $signed(rd_im_b);
		end
		if (v_s2) begin
			p_s3 <= p_s2;
			q_s3 <= q_s2;
			if (swap_s2) begin
				wr0_s3 <= qr_s2;
				wi0_s3 <= qi_s2;
				wr1_s3 <= er_s2;
				wi1_s3 <= ei_s2;
			end else begin
				wr0_s3 <= sat36(s0);
				wi0_s3 <= sat36(s1);
				wr1_s3 <= sat36(d0);
				wi1_s3 <= sat36(d1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
			state_q <= ST_IDLE;
			cnt_q <= '0;
			stage_q <= '0;
			last_q <= 1'b0;
			rd_ok_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
				inv_q <= pwdata[0];
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.op)
							OP_RUN: begin
								state_q <= ST_SWAP;
								cnt_q <= '0;
							end
							OP_READ: begin
								state_q <= ST_READ;
								rd_ok_q <= in_range;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_SWAP: begin
					if (advance) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == {AW{1'b1}}) begin
							cnt_q <= '0;
							stage_q <= '0;
							last_q <= 1'b0;
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_BFLY: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == HALF_LAST) begin
							cnt_q <= '0;
							state_q <= ST_DRAIN;
							if (stage_q == STAGE_LAST) begin
								last_q <= 1'b1;
							end else begin
								stage_q <= stage_q + 1'b1;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
						state_q <= last_q ? ST_ACK : ST_BFLY;
					end
				end
				ST_ACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		result_valid = (state_q == ST_READ) || (state_q == ST_ACK);
		result.is_done_ack = (state_q == ST_ACK);
		if ((state_q == ST_READ) && rd_ok_q) begin
			result.bin_real = $signed(rd_re_a);
			result.bin_imag = $signed(rd_im_a);
		end else begin
			result.bin_real = '0;
			result.bin_imag = '0;
		end
	end

endmodule

FILE: design/r2fft_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module r2fft_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: tb/sv/tb_radix2_fft_inverse_scaled.sv
// Self-checking testbench for the radix-2 FFT engine: predicts every bin and transform acknowledge.
module tb_radix2_fft_inverse_scaled;
	import r2fft_pkg::*;

	localparam int N = FFT_SIZE_DEF;
	localparam int LG = 11;
	localparam int QTR = N / 4;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [2:0] ADDR_INVERSE_MODE = 3'd0;
	localparam longint LIM = (64'sd1 <<< 35) - 1;

	class fft_scoreboard;
		longint frame_re[N];
		longint frame_im[N];
		longint rom_c[QTR + 1];
		longint rom_s[QTR + 1];
		bit inverse;
		fft_out_t bins_due[$];
		int errors;

		function new();
			logic [127:0] p;
			logic [63:0] x, x2, st, ss, ct, cs;
			inverse = 0;
			errors = 0;
			for (int k = 0; k <= QTR; k++) begin
				x = (PI_Q60 >> (LG - 1)) * 64'(k);
				p = 128'(x) * 128'(x);
				x2 = p[123:60];
				st = x;
				ss = x;
				ct = ONE_Q60;
				cs = ONE_Q60;
				for (int n = 1; n <= 12; n++) begin
					p = 128'(st) * 128'(x2);
					st = p[123:60] / 64'((2 * n) * (2 * n + 1));
					p = 128'(ct) * 128'(x2);
					ct = p[123:60] / 64'((2 * n - 1) * (2 * n));
					if (n % 2 == 1) begin
						ss = ss - st;
						cs = cs - ct;
					end else begin
						ss = ss + st;
						cs = cs + ct;
					end
				end
				rom_c[k] = quantize(cs);
				rom_s[k] = quantize(ss);
			end
		endfunction

		function longint quantize(logic [63:0] v);
			logic [63:0] r;
			if (v > (64'd1 << 62)) return 0;
			r = (v + (64'd1 << 44)) >> 45;
			if (r > 64'd32767) return 32767;
			return longint'(r);
		endfunction

		function longint twiddle_mac(longint a, longint wa, longint b, longint wb);
			longint x;
			x = a * wa - b * wb;
			return (x + (64'sd1 <<< 14)) >>> 15;
		endfunction

		function longint clip36(longint v);
			if (v > LIM) return LIM;
			if (v < -LIM - 1) return -LIM - 1;
			return v;
		endfunction

		function void transform_frame();
			int r, q, p, k, span;
			longint t, wc, ws, tr, ti, er, ei, s0, s1, d0, d1;
			for (int i = 0; i < N; i++) begin
				r = 0;
				for (int b = 0; b < LG; b++) r = (r << 1) | ((i >> b) & 1);
				if (r > i) begin
					t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
					t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
				end
			end
			for (int len = 2; len <= N; len = len * 2) begin
				span = len / 2;
				for (int base = 0; base < N; base += len) begin
					for (int j = 0; j < span; j++) begin
						k = j * (N / len);
						p = base + j;
						q = p + span;
						if (k <= QTR) begin
							wc = rom_c[k];
							ws = rom_s[k];
						end else begin
							wc = -rom_s[k - QTR];
							ws = rom_c[k - QTR];
						end
						if (inverse) ws = -ws;
						tr = twiddle_mac(frame_re[q], wc, frame_im[q], ws);
						ti = twiddle_mac(frame_re[q], ws, frame_im[q], -wc);
						er = frame_re[p];
						ei = frame_im[p];
						s0 = er + tr; s1 = ei + ti; d0 = er - tr; d1 = ei - ti;
						if (inverse) begin
							s0 = s0 >>> 1; s1 = s1 >>> 1; d0 = d0 >>> 1; d1 = d1 >>> 1;
						end
						frame_re[p] = clip36(s0); frame_im[p] = clip36(s1);
						frame_re[q] = clip36(d0); frame_im[q] = clip36(d1);
					end
				end
			end
		endfunction

		function void note_item(fft_in_t it);
			fft_out_t o;
			o = '0;
			case (it.op)
				OP_LOAD: begin
					frame_re[it.index] = longint'(it.sample_real);
					frame_im[it.index] = longint'(it.sample_imag);
				end
				OP_RUN: begin
					transform_frame();
					o.is_done_ack = 1'b1;
					bins_due.push_back(o);
				end
				OP_READ: begin
					o.bin_real = frame_re[it.index][35:0];
					o.bin_imag = frame_im[it.index][35:0];
					bins_due.push_back(o);
				end
				default: ;
			endcase
		endfunction

		function void check_result(fft_out_t got);
			fft_out_t want;
			if (bins_due.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = bins_due.pop_front();
			if (got.bin_real !== want.bin_real) begin
				$display("%0t: bin_real expected %0d got %0d", $time, want.bin_real, got.bin_real);
				errors++;
			end
			if (got.bin_imag !== want.bin_imag) begin
				$display("%0t: bin_imag expected %0d got %0d", $time, want.bin_imag, got.bin_imag);
				errors++;
			end
			if (got.is_done_ack !== want.is_done_ack) begin
				$display("%0t: is_done_ack expected %b got %b", $time, want.is_done_ack,
					got.is_done_ack);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	fft_in_t item = '0;
	logic result_valid;
	fft_out_t result;

	fft_scoreboard sb;
	bit gaps_on = 1;

	radix2_fft_inverse_scaled u_top (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .item(item), .result_valid(result_valid), .result(result)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#8000000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			sb.check_result(result);
		end
	end

	task automatic send_item(fft_in_t it);
		while (gaps_on && $urandom_range(99) < 32) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_item(it);
	endtask

	task automatic send_op(logic [OP_W-1:0] op, int idx, int re, int im);
		fft_in_t it;
		it.op = op;
		it.index = idx[10:0];
		it.sample_real = re[23:0];
		it.sample_imag = im[23:0];
		send_item(it);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		@(posedge clk);
		while (sb.bins_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		wait_quiet();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_INVERSE_MODE;
		pwdata <= {31'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.inverse = m;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic fill_frame();
		for (int i = 0; i < N; i++) begin
			if (i % 8 == 0) send_op(OP_LOAD, i, 8388607, -8388608);
			else send_op(OP_LOAD, i, $urandom, $urandom);
		end
	endtask

	initial begin
		int r;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		fill_frame();
		send_op(OP_LOAD, 0, 8388607, 8388607);
		send_op(OP_LOAD, N - 1, -8388608, -8388608);
		send_op(OP_LOAD, 1, 0, -1);
		send_op(OP_SPARE, 5, $urandom, $urandom);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_READ, N - 1, 0, 0);
		send_op(OP_READ, 1, 0, 0);
		send_op(OP_RUN, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_READ, 1, 0, 0);
		send_op(OP_READ, N - 1, 0, 0);
		write_mode(1'b1);
		send_op(OP_RUN, 0, 0, 0);
		send_op(OP_READ, 0, 0, 0);
		send_op(OP_READ, N - 1, 0, 0);

		for (int ph = 0; ph < 6; ph++) begin
			write_mode(ph % 2 == 0);
			gaps_on = (ph != 2);
			for (int n = 0; n < 24; n++) begin
				r = $urandom_range(99);
				if (r < 55) send_op(OP_LOAD, $urandom_range(N - 1), $urandom, $urandom);
				else if (r < 94) send_op(OP_READ, $urandom_range(N - 1), 0, 0);
				else send_op(OP_SPARE, $urandom_range(N - 1), $urandom, $urandom);
			end
			send_op(OP_RUN, $urandom_range(N - 1), $urandom, $urandom);
			for (int n = 0; n < 10; n++) send_op(OP_READ, $urandom_range(N - 1), 0, 0);
		end

		wait_quiet();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
